[hdl/tfs_pkg.sv]
package tfs_pkg;

   localparam int FC_W   = 7;   // frame_count register
   localparam int ACT_W  = 3;
   localparam int MS_W   = 16;  // elapsed_ms, frame_duration, time in frame
   localparam int FN_W   = 6;   // frame_number, shown_frame
   localparam int ST_W   = 2;
   localparam int PASS_W = MS_W + 1;  // elapsed plus time in frame

   typedef enum logic [ST_W-1:0] {
      ST_STOP  = 2'd0,
      ST_PLAY  = 2'd1,
      ST_PAUSE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MD_SINGLE = 2'd0,
      MD_ONCE   = 2'd1,
      MD_LOOP   = 2'd2
   } mode_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_TICK   = 3'd0,
      ACT_ONCE   = 3'd1,
      ACT_LOOP   = 3'd2,
      ACT_SHOW   = 3'd3,
      ACT_PAUSE  = 3'd4,
      ACT_RESUME = 3'd5,
      ACT_STOP   = 3'd6,
      ACT_LOAD   = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_SUMD,
      S_CHK,
      S_MOD,
      S_WREQ,
      S_WCHK,
      S_FIN
   } fsm_type;

endpackage

[hdl/tfs_req_if.sv]
interface tfs_req_if;
   logic                      valid;
   logic                      ready;
   logic [tfs_pkg::ACT_W-1:0] action;
   logic [tfs_pkg::MS_W-1:0]  elapsed_ms;
   logic [tfs_pkg::FN_W-1:0]  frame_number;
   logic [tfs_pkg::MS_W-1:0]  frame_duration;

   modport source (output valid, action, elapsed_ms, frame_number, frame_duration,
                   input ready);
   modport sink   (input valid, action, elapsed_ms, frame_number, frame_duration,
                   output ready);
endinterface

[hdl/tfs_rsp_if.sv]
interface tfs_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [tfs_pkg::FN_W-1:0] shown_frame;
   logic                     visible;
   logic [tfs_pkg::ST_W-1:0] play_status;
   logic                     accepted;

   modport source (output valid, shown_frame, visible, play_status, accepted,
                   input ready);
   modport sink   (input valid, shown_frame, visible, play_status, accepted,
                   output ready);
endinterface

[hdl/tfs_csr_if.sv]
interface tfs_csr_if;
   logic                     valid;
   logic                     ready;
   logic [tfs_pkg::FC_W-1:0] frame_count;

   modport source (output valid, frame_count, input ready);
   modport sink   (input valid, frame_count, output ready);
endinterface

[hdl/timed_frame_sequencer.sv]
// channel  dir  handshake          payload
// req_ch   in   valid/ready        action, elapsed_ms, frame_number, frame_duration
// rsp_ch   out  valid/ready        shown_frame, visible, play_status, accepted
// csr_ch   in   valid/ready        frame_count (ready always high)
//
// Commands and ticks that do not walk finish in the accept cycle; the item
// shows on rsp_ch in the next cycle. A walking tick sums the duration table
// through the RAM read port, folds the time modulo the sum when it must,
// visits each frame with a read and a compare, and then delivers. The next
// item is taken once the sequencer is idle and the result register is free.
// Reset is synchronous; the duration RAM is not cleared.
module timed_frame_sequencer #(
   parameter int MAX_FRAMES = 64
) (
   input  logic       clock,
   input  logic       reset,
   tfs_req_if.sink    req_ch,
   tfs_rsp_if.source  rsp_ch,
   tfs_csr_if.sink    csr_ch
);

   localparam int AW  = $clog2(MAX_FRAMES);
   localparam int CW  = $clog2(MAX_FRAMES + 1);
   localparam int FCW = tfs_pkg::FC_W;
   localparam int CWX = (CW > FCW) ? CW : FCW;
   localparam int FNW = tfs_pkg::FN_W;
   localparam int XW  = (AW > FNW) ? AW : FNW;
   localparam int MSW = tfs_pkg::MS_W;
   localparam int SW  = MSW + AW;
   localparam int PW  = tfs_pkg::PASS_W;
   localparam int BW  = $clog2(PW);

   tfs_pkg::fsm_type    state_ff, state_in;
   tfs_pkg::status_type status_ff, status_in;
   tfs_pkg::mode_type   mode_ff, mode_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [FNW-1:0]      fixed_ff, fixed_in;
   logic [MSW-1:0]      time_ff, time_in;
   logic [FCW-1:0]      frame_count_ff, frame_count_in;

   logic [SW-1:0]       sum_ff, sum_in;
   logic [AW-1:0]       sa_ff, sa_in;
   logic                rdp_ff, rdp_in;
   logic [PW-1:0]       pass_ff, pass_in;
   logic [PW-1:0]       rem_ff, rem_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [AW-1:0]       idx_ff, idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FNW-1:0]      rsp_frame_ff, rsp_frame_in;
   logic                rsp_vis_ff, rsp_vis_in;
   tfs_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_acc_ff, rsp_acc_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [AW-1:0]       ram_rd_addr;
   logic [MSW-1:0]      ram_rd_data;

   tfs_pkg::action_type act;
   logic [CWX-1:0]      fc_x;
   logic [CW-1:0]       count;
   logic                slot_free;
   logic                req_fire;
   logic                walk_go;
   logic                rsp_load;
   logic                acc_in;
   logic [PW:0]         r2;
   logic [PW:0]         sum_x;
   logic                vis_in;

   tfs_ram #(
      .WIDTH (MSW),
      .DEPTH (MAX_FRAMES)
   ) u_dur_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_ch.frame_duration),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign act       = tfs_pkg::action_type'(req_ch.action);
   assign fc_x      = CWX'(frame_count_ff);
   assign count     = (fc_x > CWX'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fc_x);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == tfs_pkg::S_IDLE) && slot_free;
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign walk_go   = (act == tfs_pkg::ACT_TICK) && (mode_ff != tfs_pkg::MD_SINGLE) &&
                      (status_ff == tfs_pkg::ST_PLAY) && (count != '0);
   assign rsp_load  = ((state_ff == tfs_pkg::S_IDLE) && req_fire && !walk_go) ||
                      ((state_ff == tfs_pkg::S_FIN) && slot_free);
   assign csr_ch.ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfs_pkg::S_IDLE: begin
            if (req_fire && walk_go) state_in = tfs_pkg::S_SUM;
         end
         tfs_pkg::S_SUM: begin
            if (CW'(sa_ff) + CW'(1) == count) state_in = tfs_pkg::S_SUMD;
         end
         tfs_pkg::S_SUMD: state_in = tfs_pkg::S_CHK;
         tfs_pkg::S_CHK: begin
            if (sum_ff == '0) state_in = tfs_pkg::S_FIN;
            else if (SW'(pass_ff) > sum_ff) state_in = tfs_pkg::S_MOD;
            else state_in = tfs_pkg::S_WREQ;
         end
         tfs_pkg::S_MOD: begin
            if (bit_ff == '0) state_in = tfs_pkg::S_WREQ;
         end
         tfs_pkg::S_WREQ: state_in = tfs_pkg::S_WCHK;
         tfs_pkg::S_WCHK: begin
            if (pass_ff <= PW'(ram_rd_data)) state_in = tfs_pkg::S_FIN;
            else state_in = tfs_pkg::S_WREQ;
         end
         tfs_pkg::S_FIN: begin
            if (slot_free) state_in = tfs_pkg::S_IDLE;
         end
         default: state_in = tfs_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      status_in      = status_ff;
      mode_in        = mode_ff;
      cur_in         = cur_ff;
      fixed_in       = fixed_ff;
      time_in        = time_ff;
      frame_count_in = frame_count_ff;
      sum_in         = sum_ff;
      sa_in          = sa_ff;
      pass_in        = pass_ff;
      rem_in         = rem_ff;
      bit_in         = bit_ff;
      idx_in         = idx_ff;
      acc_in         = 1'b1;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = AW'(XW'(req_ch.frame_number));
      ram_rd_addr    = '0;
      rdp_in         = (state_ff == tfs_pkg::S_SUM);
      sum_x          = {2'b00, sum_ff[PW-2:0]};
      r2             = {rem_ff, pass_ff[PW-1]};

      if (csr_ch.valid) frame_count_in = csr_ch.frame_count;

      case (state_ff)
         tfs_pkg::S_IDLE: begin
            if (req_fire) begin
               case (act)
                  tfs_pkg::ACT_TICK: begin
                     if (walk_go) begin
                        sum_in = '0;
                        sa_in  = '0;
                        // count lowered under the current frame: restart the walk
                        if (CW'(cur_ff) >= count) begin
                           cur_in  = '0;
                           time_in = '0;
                           pass_in = PW'(req_ch.elapsed_ms);
                        end else begin
                           pass_in = PW'(req_ch.elapsed_ms) + PW'(time_ff);
                        end
                     end
                  end
                  tfs_pkg::ACT_ONCE, tfs_pkg::ACT_LOOP: begin
                     mode_in   = (act == tfs_pkg::ACT_ONCE) ? tfs_pkg::MD_ONCE
                                                            : tfs_pkg::MD_LOOP;
                     status_in = tfs_pkg::ST_PLAY;
                     cur_in    = '0;
                     time_in   = '0;
                  end
                  tfs_pkg::ACT_SHOW: begin
                     if (32'(req_ch.frame_number) < 32'(count)) begin
                        fixed_in  = req_ch.frame_number;
                        mode_in   = tfs_pkg::MD_SINGLE;
                        status_in = tfs_pkg::ST_PLAY;
                     end else begin
                        acc_in = 1'b0;
                     end
                  end
                  tfs_pkg::ACT_PAUSE: begin
                     if (status_ff == tfs_pkg::ST_PLAY) status_in = tfs_pkg::ST_PAUSE;
                  end
                  tfs_pkg::ACT_RESUME: begin
                     if (status_ff == tfs_pkg::ST_PAUSE) status_in = tfs_pkg::ST_PLAY;
                  end
                  tfs_pkg::ACT_STOP: begin
                     status_in = tfs_pkg::ST_STOP;
                     if (mode_ff == tfs_pkg::MD_LOOP) mode_in = tfs_pkg::MD_ONCE;
                  end
                  tfs_pkg::ACT_LOAD: begin
                     ram_wr_en = (32'(req_ch.frame_number) < MAX_FRAMES);
                  end
                  default: begin
                  end
               endcase
            end
         end
         tfs_pkg::S_SUM: begin
            ram_rd_addr = sa_ff;
            sa_in       = sa_ff + AW'(1);
            if (rdp_ff) sum_in = sum_ff + SW'(ram_rd_data);
         end
         tfs_pkg::S_SUMD: begin
            if (rdp_ff) sum_in = sum_ff + SW'(ram_rd_data);
         end
         tfs_pkg::S_CHK: begin
            idx_in = cur_ff;
            if (sum_ff == '0) begin
               // all durations zero: one full pass, back on the same frame
               if (pass_ff != '0) time_in = '0;
            end else if (SW'(pass_ff) > sum_ff) begin
               pass_in = pass_ff - PW'(1);
               rem_in  = '0;
               bit_in  = BW'(PW - 1);
            end
         end
         tfs_pkg::S_MOD: begin
            // restoring remainder, one dividend bit a cycle; sum fits PW bits here
            sum_x = {1'b0, sum_ff[PW-1:0]};
            r2    = {rem_ff, pass_ff[PW-1]};
            if (r2 >= sum_x) r2 = r2 - sum_x;
            rem_in  = r2[PW-1:0];
            pass_in = {pass_ff[PW-2:0], 1'b0};
            bit_in  = bit_ff - BW'(1);
            if (bit_ff == '0) pass_in = r2[PW-1:0] + PW'(1);
         end
         tfs_pkg::S_WREQ: begin
            ram_rd_addr = idx_ff;
         end
         tfs_pkg::S_WCHK: begin
            if (pass_ff <= PW'(ram_rd_data)) begin
               cur_in  = idx_ff;
               time_in = pass_ff[MSW-1:0];
            end else begin
               pass_in = pass_ff - PW'(ram_rd_data);
               if (CW'(idx_ff) + CW'(1) >= count) idx_in = '0;
               else idx_in = idx_ff + AW'(1);
            end
         end
         tfs_pkg::S_FIN: begin
         end
         default: begin
         end
      endcase

      vis_in        = (status_in != tfs_pkg::ST_STOP) && (count != '0);
      rsp_vis_in    = vis_in;
      rsp_status_in = status_in;
      rsp_acc_in    = acc_in;
      if (!vis_in) rsp_frame_in = '0;
      else if (mode_in == tfs_pkg::MD_SINGLE) rsp_frame_in = fixed_in;
      else rsp_frame_in = FNW'(XW'(cur_in));

      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tfs_pkg::S_IDLE;
         status_ff      <= tfs_pkg::ST_STOP;
         mode_ff        <= tfs_pkg::MD_SINGLE;
         cur_ff         <= '0;
         fixed_ff       <= '0;
         time_ff        <= '0;
         frame_count_ff <= FCW'(1);
         rdp_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         status_ff      <= status_in;
         mode_ff        <= mode_in;
         cur_ff         <= cur_in;
         fixed_ff       <= fixed_in;
         time_ff        <= time_in;
         frame_count_ff <= frame_count_in;
         rdp_ff         <= rdp_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      sa_ff   <= sa_in;
      pass_ff <= pass_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      idx_ff  <= idx_in;
      if (rsp_load) begin
         rsp_frame_ff  <= rsp_frame_in;
         rsp_vis_ff    <= rsp_vis_in;
         rsp_status_ff <= rsp_status_in;
         rsp_acc_ff    <= rsp_acc_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.shown_frame = rsp_frame_ff;
   assign rsp_ch.visible     = rsp_vis_ff;
   assign rsp_ch.play_status = rsp_status_ff;
   assign rsp_ch.accepted    = rsp_acc_ff;

   a_mod_nonzero_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == tfs_pkg::S_MOD |-> sum_ff != '0)
      else $error("remainder step with zero duration sum");

   a_walk_within_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == tfs_pkg::S_WREQ |-> SW'(pass_ff) <= sum_ff)
      else $error("walk started with time beyond one pass");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == tfs_pkg::S_WREQ |-> CW'(idx_ff) < count)
      else $error("walk index outside frame count");

   a_sum_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == tfs_pkg::S_SUM |-> CW'(sa_ff) < count)
      else $error("sum sweep past frame count");

   a_fin_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tfs_pkg::S_FIN && slot_free) |=>
         (rsp_valid_ff && state_ff == tfs_pkg::S_IDLE))
      else $error("tick result not delivered");

endmodule

[hdl/tfs_ram.sv]
module tfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

   localparam int FRAMES         = 64;
   localparam int SETTLE         = 8;
   localparam int TAIL           = 30;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 72;
   localparam int PHASES         = 8;
   localparam logic [tfs_pkg::FC_W-1:0] PHASE_COUNT [PHASES] =
      '{7'd127, 7'd64, 7'd1, 7'd7, 7'd0, 7'd33, 7'd2, 7'd64};

   typedef struct packed {
      tfs_pkg::action_type      action;
      logic [tfs_pkg::MS_W-1:0] elapsed_ms;
      logic [tfs_pkg::FN_W-1:0] frame_number;
      logic [tfs_pkg::MS_W-1:0] frame_duration;
   } req_item_type;

   typedef struct packed {
      logic [tfs_pkg::FN_W-1:0] shown_frame;
      logic                     visible;
      logic [tfs_pkg::ST_W-1:0] play_status;
      logic                     accepted;
   } frame_result_type;

   class frame_seq_scoreboard;
      tfs_pkg::status_type      status_q;
      tfs_pkg::mode_type        mode_q;
      logic [tfs_pkg::FN_W-1:0] cur_frame;
      logic [tfs_pkg::FN_W-1:0] fixed_frame;
      logic [tfs_pkg::MS_W-1:0] time_in_frame;
      logic [tfs_pkg::MS_W-1:0] durations [FRAMES];
      bit                       written [FRAMES];
      logic [tfs_pkg::FC_W-1:0] frame_count;
      frame_result_type         expected_q [$];
      int unsigned              errors;

      function new();
         status_q      = tfs_pkg::ST_STOP;
         mode_q        = tfs_pkg::MD_SINGLE;
         cur_frame     = '0;
         fixed_frame   = '0;
         time_in_frame = '0;
         frame_count   = 7'd1;
         errors        = 0;
         foreach (written[i]) begin
            written[i]   = 1'b0;
            durations[i] = '0;
         end
      endfunction

      function int unsigned active_count();
         return (frame_count > FRAMES) ? FRAMES : frame_count;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function bit will_walk();
         return mode_q != tfs_pkg::MD_SINGLE && status_q == tfs_pkg::ST_PLAY &&
                active_count() != 0;
      endfunction

      // lowest slot in use that has never been loaded, or -1
      function int first_unwritten();
         for (int i = 0; i < active_count(); i++)
            if (!written[i]) return i;
         return -1;
      endfunction

      function void advance_frames(int unsigned elapsed, int unsigned count);
         int unsigned total;
         int unsigned pass;
         int unsigned idx;
         total = 0;
         if (cur_frame >= count) begin
            cur_frame     = '0;
            time_in_frame = '0;
         end
         for (int i = 0; i < count; i++)
            total += durations[i];
         idx  = cur_frame;
         pass = elapsed + time_in_frame;
         if (total == 0) begin
            // every duration zero: one full pass lands back on the same frame
            if (pass != 0) time_in_frame = '0;
            return;
         end
         if (pass > total) pass = (pass - 1) % total + 1;
         for (int i = 0; i <= count; i++) begin
            if (pass <= durations[idx]) break;
            pass -= durations[idx];
            idx++;
            if (idx >= count) idx = 0;
         end
         cur_frame     = idx[tfs_pkg::FN_W-1:0];
         time_in_frame = pass[tfs_pkg::MS_W-1:0];
      endfunction

      function void note_item(req_item_type it);
         int unsigned      count;
         frame_result_type want;
         bit               vis;
         count         = active_count();
         want.accepted = 1'b1;
         case (it.action)
            tfs_pkg::ACT_TICK: begin
               if (will_walk()) advance_frames(it.elapsed_ms, count);
            end
            tfs_pkg::ACT_ONCE, tfs_pkg::ACT_LOOP: begin
               mode_q        = (it.action == tfs_pkg::ACT_ONCE) ? tfs_pkg::MD_ONCE
                                                                : tfs_pkg::MD_LOOP;
               status_q      = tfs_pkg::ST_PLAY;
               cur_frame     = '0;
               time_in_frame = '0;
            end
            tfs_pkg::ACT_SHOW: begin
               if (it.frame_number < count) begin
                  fixed_frame = it.frame_number;
                  mode_q      = tfs_pkg::MD_SINGLE;
                  status_q    = tfs_pkg::ST_PLAY;
               end else begin
                  want.accepted = 1'b0;
               end
            end
            tfs_pkg::ACT_PAUSE: begin
               if (status_q == tfs_pkg::ST_PLAY) status_q = tfs_pkg::ST_PAUSE;
            end
            tfs_pkg::ACT_RESUME: begin
               if (status_q == tfs_pkg::ST_PAUSE) status_q = tfs_pkg::ST_PLAY;
            end
            tfs_pkg::ACT_STOP: begin
               status_q = tfs_pkg::ST_STOP;
               if (mode_q == tfs_pkg::MD_LOOP) mode_q = tfs_pkg::MD_ONCE;
            end
            default: begin
               if (it.frame_number < FRAMES) begin
                  durations[it.frame_number] = it.frame_duration;
                  written[it.frame_number]   = 1'b1;
               end
            end
         endcase
         vis              = status_q != tfs_pkg::ST_STOP && count != 0;
         want.visible     = vis;
         want.play_status = status_q;
         want.shown_frame = !vis ? '0 :
                            (mode_q == tfs_pkg::MD_SINGLE) ? fixed_frame : cur_frame;
         expected_q = {expected_q, want};
      endfunction

      function void compare_field(string name, logic [tfs_pkg::MS_W-1:0] want,
                                  logic [tfs_pkg::MS_W-1:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t: result with no item outstanding", $realtime);
            return;
         end
         want = expected_q.pop_front();
         compare_field("shown_frame", want.shown_frame, got.shown_frame);
         compare_field("visible", want.visible, got.visible);
         compare_field("play_status", want.play_status, got.play_status);
         compare_field("accepted", want.accepted, got.accepted);
      endfunction
   endclass

   logic clock;
   logic reset;

   tfs_req_if req_ch ();
   tfs_rsp_if rsp_ch ();
   tfs_csr_if csr_ch ();

   timed_frame_sequencer #(.MAX_FRAMES(FRAMES)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   frame_seq_scoreboard sb = new();
   bit idle_on      = 1'b1;
   bit hold_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [tfs_pkg::MS_W-1:0] pick_ms();
      int unsigned r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 4) return tfs_pkg::MS_W'($urandom);
      return tfs_pkg::MS_W'($urandom_range(1, 150));
   endfunction

   task automatic drive_item(req_item_type it);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.action         <= it.action;
      req_ch.elapsed_ms     <= it.elapsed_ms;
      req_ch.frame_number   <= it.frame_number;
      req_ch.frame_duration <= it.frame_duration;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
   endtask

   task automatic send_cmd(tfs_pkg::action_type act, logic [tfs_pkg::MS_W-1:0] ms,
                           logic [tfs_pkg::FN_W-1:0] fn, logic [tfs_pkg::MS_W-1:0] dur);
      req_item_type it;
      int           slot;
      // a walking tick reads every slot in use: load the missing ones first
      if (act == tfs_pkg::ACT_TICK && sb.will_walk()) begin
         slot = sb.first_unwritten();
         while (slot >= 0) begin
            it.action         = tfs_pkg::ACT_LOAD;
            it.elapsed_ms     = tfs_pkg::MS_W'($urandom);
            it.frame_number   = tfs_pkg::FN_W'(slot);
            it.frame_duration = pick_ms();
            drive_item(it);
            slot = sb.first_unwritten();
         end
      end
      it.action         = act;
      it.elapsed_ms     = ms;
      it.frame_number   = fn;
      it.frame_duration = dur;
      drive_item(it);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic set_frame_count(logic [tfs_pkg::FC_W-1:0] value);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.frame_count <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid    <= 1'b0;
      sb.frame_count   = value;
   endtask

   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  pick;
      int unsigned  cnt;
      cnt               = sb.active_count();
      pick              = $urandom_range(0, 99);
      it.elapsed_ms     = pick_ms();
      it.frame_number   = tfs_pkg::FN_W'($urandom);
      it.frame_duration = pick_ms();
      if (pick < 45)      it.action = tfs_pkg::ACT_TICK;
      else if (pick < 52) it.action = tfs_pkg::ACT_ONCE;
      else if (pick < 59) it.action = tfs_pkg::ACT_LOOP;
      else if (pick < 66) it.action = tfs_pkg::ACT_SHOW;
      else if (pick < 72) it.action = tfs_pkg::ACT_PAUSE;
      else if (pick < 78) it.action = tfs_pkg::ACT_RESUME;
      else if (pick < 83) it.action = tfs_pkg::ACT_STOP;
      else                it.action = tfs_pkg::ACT_LOAD;
      // bias show and load toward slots in use
      if ((it.action == tfs_pkg::ACT_SHOW || it.action == tfs_pkg::ACT_LOAD) &&
          cnt != 0 && $urandom_range(0, 2) != 0)
         it.frame_number = tfs_pkg::FN_W'($urandom_range(0, cnt - 1));
      return it;
   endfunction

   // result side: check, then decide the next ready
   initial begin
      int unsigned      stall_left;
      frame_result_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.shown_frame = rsp_ch.shown_frame;
            got.visible     = rsp_ch.visible;
            got.play_status = rsp_ch.play_status;
            got.accepted    = rsp_ch.accepted;
            sb.check_result(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = LONG_HOLD;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      req_item_type it;
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.action         <= tfs_pkg::ACT_TICK;
      req_ch.elapsed_ms     <= '0;
      req_ch.frame_number   <= '0;
      req_ch.frame_duration <= '0;
      rsp_ch.ready          <= 1'b0;
      csr_ch.valid          <= 1'b0;
      csr_ch.frame_count    <= 7'd1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one frame after reset: commands while stopped, show range, all-zero walk
      send_cmd(tfs_pkg::ACT_TICK, 16'd100, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_SHOW, 16'd0, 6'd1, 16'd0);
      send_cmd(tfs_pkg::ACT_SHOW, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_PAUSE, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_RESUME, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_STOP, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_RESUME, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_LOAD, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_LOAD, 16'hFFFF, 6'd63, 16'hFFFF);
      send_cmd(tfs_pkg::ACT_LOOP, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_TICK, 16'hFFFF, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_STOP, 16'd0, 6'd0, 16'd0);

      // four frames: walks, pause, then land on the last frame
      set_frame_count(7'd4);
      send_cmd(tfs_pkg::ACT_LOAD, 16'd0, 6'd1, 16'd10);
      send_cmd(tfs_pkg::ACT_LOAD, 16'd0, 6'd2, 16'd0);
      send_cmd(tfs_pkg::ACT_LOAD, 16'd0, 6'd3, 16'hFFFF);
      send_cmd(tfs_pkg::ACT_ONCE, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_TICK, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_TICK, 16'd11, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_TICK, 16'hFFFF, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_PAUSE, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_TICK, 16'd50, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_RESUME, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_LOOP, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_TICK, 16'd20, 6'd0, 16'd0);

      // count lowered under the current frame: tick restarts at frame 0
      set_frame_count(7'd2);
      send_cmd(tfs_pkg::ACT_TICK, 16'd5, 6'd0, 16'd0);

      // no frames: nothing visible, show rejected
      set_frame_count(7'd0);
      send_cmd(tfs_pkg::ACT_SHOW, 16'd0, 6'd0, 16'd0);
      send_cmd(tfs_pkg::ACT_TICK, 16'd7, 6'd0, 16'd0);

      for (int p = 0; p < PHASES; p++) begin
         set_frame_count(PHASE_COUNT[p]);
         if (p == PHASES - 1) idle_on = 1'b0;
         if (p == 1) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
            it = random_item();
            send_cmd(it.action, it.elapsed_ms, it.frame_number, it.frame_duration);
         end
      end

      wait_drained();
      repeat (TAIL) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
